// File: sv/pwmaet_pkg.sv
// shared widths, codes, reset values and control structs for the pwm encoder tracker
// no dependencies; used by the interfaces, the history unit and the top level
`default_nettype none

package pwmaet_pkg;

   localparam int TIME_W     = 32;
   localparam int POS_W      = 13;
   localparam int TURN_W     = 32;
   localparam int DIR_W      = 2;
   localparam int STAT_W     = 3;
   localparam int WIN_W      = 5;
   localparam int ALU_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int PULSES_PER_REV_DEF = 4096;
   localparam int HISTORY_DEPTH_DEF  = 16;

   localparam int MIN_EDGE_GAP = 2;
   localparam int STILL_DIV    = 333;
   localparam int DIR_DIV      = 167;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type ST_MOVED  = 3'd0;
   localparam status_type ST_START  = 3'd1;
   localparam status_type ST_TIMING = 3'd2;
   localparam status_type ST_WIDTH  = 3'd3;
   localparam status_type ST_NOISE  = 3'd4;
   localparam status_type ST_ZERO   = 3'd5;
   localparam status_type ST_STILL  = 3'd6;

   typedef logic [DIR_W-1:0] dir_type;
   localparam dir_type DIR_UNKNOWN = 2'd0;
   localparam dir_type DIR_CW      = 2'd1;
   localparam dir_type DIR_CCW     = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_FILTER_EN = 3'd0;
   localparam csr_idx_type CSR_WINDOW    = 3'd1;
   localparam csr_idx_type CSR_NOISE     = 3'd2;
   localparam csr_idx_type CSR_MIN_WIDTH = 3'd3;
   localparam csr_idx_type CSR_MAX_WIDTH = 3'd4;

   localparam logic             FILTER_EN_RST = 1'b1;
   localparam logic [WIN_W-1:0] WINDOW_RST    = 5'd16;
   localparam logic [POS_W-1:0] NOISE_RST     = 13'd0;
   localparam logic [POS_W-1:0] MIN_WIDTH_RST = 13'd1;
   localparam logic [POS_W-1:0] MAX_WIDTH_RST = 13'd4097;

   // sequencer to history unit
   typedef struct packed {
      logic clear;
      logic push;
   } hist_cmd_type;

   // history unit back to sequencer
   typedef struct packed {
      logic rd_valid;
      logic rd_last;
   } hist_stat_type;

endpackage

`default_nettype wire

// File: sv/pwmaet_ifs.sv
// valid/ready channel interfaces for edge events in and tracker results out
// depends on pwmaet_pkg for field widths
`default_nettype none

interface pwmaet_req_if;
   logic                            valid;
   logic                            ready;
   logic [pwmaet_pkg::TIME_W-1:0]   edge_time;
   logic                            edge_level;

   modport source (output valid, edge_time, edge_level, input ready);
   modport sink   (input valid, edge_time, edge_level, output ready);
endinterface

interface pwmaet_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [pwmaet_pkg::STAT_W-1:0]        status;
   logic [pwmaet_pkg::POS_W-1:0]         position;
   logic signed [pwmaet_pkg::TURN_W-1:0] turns;
   logic [pwmaet_pkg::DIR_W-1:0]         direction;

   modport source (output valid, status, position, turns, direction, input ready);
   modport sink   (input valid, status, position, turns, direction, output ready);
endinterface

`default_nettype wire

// File: sv/pwmaet_hist.sv
// position history ring with fill count, streams the newest n entries after each push
// depends on pwmaet_pkg (widths, hist_cmd_type, hist_stat_type)
`default_nettype none

module pwmaet_hist #(
   parameter int HISTORY_DEPTH = pwmaet_pkg::HISTORY_DEPTH_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  pwmaet_pkg::hist_cmd_type                  cmd,
   input  wire [pwmaet_pkg::POS_W-1:0]               push_data,
   input  wire [pwmaet_pkg::WIN_W-1:0]               window,
   output pwmaet_pkg::hist_stat_type                 stat,
   output logic [pwmaet_pkg::POS_W-1:0]              rd_data,
   output logic [$clog2(HISTORY_DEPTH+1)-1:0]        avg_n
);
   import pwmaet_pkg::*;

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH+1);
   localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH-1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

   logic [POS_W-1:0] hist_mem [HISTORY_DEPTH];

   logic [IDX_W-1:0] wr_idx_ff,   wr_idx_in;
   logic [IDX_W-1:0] rd_ptr_ff,   rd_ptr_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [CNT_W-1:0] left_ff,     left_in;
   logic [CNT_W-1:0] n_ff,        n_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff,  rd_last_in;
   logic [POS_W-1:0] rd_data_ff;

   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] n_next;

   always_comb begin
      count_inc = (count_ff == DEPTH_CNT) ? count_ff : count_ff + 1'b1;
      // n = min(fill after this push, window)
      if (CMP_W'(count_inc) < CMP_W'(window)) begin
         n_next = count_inc;
      end else begin
         n_next = CNT_W'(window);
      end

      wr_idx_in   = wr_idx_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      n_in        = n_ff;
      rd_valid_in = 1'b0;
      rd_last_in  = 1'b0;

      if (cmd.clear) begin
         wr_idx_in = '0;
         count_in  = '0;
         left_in   = '0;
      end else if (cmd.push) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         count_in  = count_inc;
         rd_ptr_in = wr_idx_ff;
         left_in   = n_next;
         n_in      = n_next;
      end else if (left_ff != '0) begin
         // walk back from the newest entry, one read a cycle
         rd_valid_in = 1'b1;
         rd_last_in  = (left_ff == CNT_W'(1));
         left_in     = left_ff - 1'b1;
         rd_ptr_in   = (rd_ptr_ff == '0) ? LAST_IDX : rd_ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         left_ff     <= '0;
         n_ff        <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         wr_idx_ff   <= wr_idx_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         left_ff     <= left_in;
         n_ff        <= n_in;
         rd_valid_ff <= rd_valid_in;
         rd_last_ff  <= rd_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         hist_mem[wr_idx_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (!cmd.push && !cmd.clear && left_ff != '0) begin
         rd_data_ff <= hist_mem[rd_ptr_ff];
      end
   end

   assign stat.rd_valid = rd_valid_ff;
   assign stat.rd_last  = rd_last_ff;
   assign rd_data       = rd_data_ff;
   assign avg_n         = n_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("history fill count above depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.push && !cmd.clear |=> count_ff != '0)
      else $error("history empty right after a push");

   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (n_ff != '0) && (n_ff <= count_ff))
      else $error("averaging window outside filled history");

endmodule

`default_nettype wire

// File: sv/pwm_absolute_encoder_tracker.sv
// top level of the pwm absolute encoder tracker: csr bank, sequencer and shared 32-bit alu
// depends on pwmaet_pkg, pwmaet_ifs (req/rsp channels) and pwmaet_hist
//
//   port      | dir | handshake        | beat contents
//   ----------+-----+------------------+------------------------------------------
//   req_if    | in  | valid / ready    | edge_time[31:0], edge_level
//   rsp_if    | out | valid / ready    | status[2:0], position[12:0], turns[31:0], direction[1:0]
//   csr_*     | in  | csr_wr_en only   | csr_index[2:0], csr_wr_data[12:0]
//
// one edge at a time: ready only while idle, the result beat is held until taken
// timing and start outcomes come from S_GAP, width and zero ones from S_WIDTH; an unfiltered
// position goes through S_NOISE and S_TRACK (S_TURN on a wrap), an averaged one also S_SUM and
// S_DIV, the history read sweep and the bit-serial divide on the shared alu
// synchronous active-high reset; history needs no clearing pass, the fill count covers it
`default_nettype none

module pwm_absolute_encoder_tracker #(
   parameter int PULSES_PER_REV = pwmaet_pkg::PULSES_PER_REV_DEF,
   parameter int HISTORY_DEPTH  = pwmaet_pkg::HISTORY_DEPTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire [pwmaet_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [pwmaet_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   pwmaet_req_if.sink                           req_if,
   pwmaet_rsp_if.source                         rsp_if
);
   import pwmaet_pkg::*;

   localparam int CNT_W  = $clog2(HISTORY_DEPTH+1);
   localparam int SUM_W  = POS_W + $clog2(HISTORY_DEPTH);
   localparam int BCNT_W = $clog2(SUM_W+1);

   localparam logic [POS_W:0]    HALF_TURN = (POS_W+1)'(PULSES_PER_REV / 2);
   localparam logic [POS_W:0]    STILL_LIM = (POS_W+1)'(PULSES_PER_REV / STILL_DIV);
   localparam logic [POS_W:0]    DIR_LIM   = (POS_W+1)'(PULSES_PER_REV / DIR_DIV);
   localparam logic [ALU_W-1:0]  REV_X     = ALU_W'(PULSES_PER_REV);
   localparam logic [POS_W-1:0]  REV_TOP   = POS_W'(PULSES_PER_REV - 1);
   localparam logic [ALU_W-1:0]  EDGE_GAP  = ALU_W'(MIN_EDGE_GAP);
   localparam logic [BCNT_W-1:0] DIV_STEPS = BCNT_W'(SUM_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_GAP,
      S_WIDTH,
      S_NOISE,
      S_SUM,
      S_DIV,
      S_TRACK,
      S_TURN,
      S_RESP
   } state_type;

   state_type         state_ff,      state_in;
   logic [TIME_W-1:0] edge_time_ff,  edge_time_in;
   logic              edge_level_ff, edge_level_in;
   logic [TIME_W-1:0] last_edge_ff,  last_edge_in;
   logic [TIME_W-1:0] pulse_start_ff, pulse_start_in;
   logic [POS_W-1:0]  last_pos_ff,   last_pos_in;
   logic [TURN_W-1:0] turns_ff,      turns_in;
   dir_type           dir_ff,        dir_in;
   status_type        status_ff,     status_in;
   logic [POS_W-1:0]  cand_ff,       cand_in;
   logic [SUM_W-1:0]  acc_ff,        acc_in;
   logic [CNT_W-1:0]  rem_ff,        rem_in;
   logic [BCNT_W-1:0] bit_cnt_ff,    bit_cnt_in;
   logic              turn_up_ff,    turn_up_in;

   logic              filt_en_ff,    filt_en_in;
   logic [WIN_W-1:0]  window_ff,     window_in;
   logic [POS_W-1:0]  noise_ff,      noise_in;
   logic [POS_W-1:0]  min_w_ff,      min_w_in;
   logic [POS_W-1:0]  max_w_ff,      max_w_in;

   // shared alu: a + (b or ~b) + cin, carry out on top
   logic [ALU_W-1:0]  alu_a;
   logic [ALU_W-1:0]  alu_b;
   logic              alu_inv;
   logic              alu_cin;
   logic [ALU_W:0]    alu_sum;

   logic [POS_W:0]    diff_lo;
   logic              diff_neg;
   logic [POS_W:0]    abs_diff;
   logic [POS_W-1:0]  width_pos;
   logic              big_jump;
   dir_type           new_dir;
   logic [CNT_W:0]    rem_shift;

   hist_cmd_type      hist_cmd;
   hist_stat_type     hist_stat;
   logic [POS_W-1:0]  hist_rd_data;
   logic [CNT_W-1:0]  avg_n;

   pwmaet_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .cmd       (hist_cmd),
      .push_data (cand_ff),
      .window    (window_ff),
      .stat      (hist_stat),
      .rd_data   (hist_rd_data),
      .avg_n     (avg_n)
   );

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_inv = 1'b1;
      alu_cin = 1'b1;
      case (state_ff)
         S_GAP: begin
            alu_a = edge_time_ff;
            alu_b = last_edge_ff;
         end
         S_WIDTH: begin
            // t - start - 1
            alu_a   = edge_time_ff;
            alu_b   = pulse_start_ff;
            alu_cin = 1'b0;
         end
         S_NOISE, S_TRACK: begin
            alu_a = ALU_W'(cand_ff);
            alu_b = ALU_W'(last_pos_ff);
         end
         S_SUM: begin
            alu_a   = ALU_W'(acc_ff);
            alu_b   = ALU_W'(hist_rd_data);
            alu_inv = 1'b0;
            alu_cin = 1'b0;
         end
         S_DIV: begin
            alu_a = ALU_W'({rem_ff, acc_ff[SUM_W-1]});
            alu_b = ALU_W'(avg_n);
         end
         S_TURN: begin
            alu_a   = turns_ff;
            alu_b   = turn_up_ff ? '0 : '1;
            alu_inv = 1'b0;
            alu_cin = turn_up_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
      alu_sum = {1'b0, alu_a} + {1'b0, (alu_inv ? ~alu_b : alu_b)} + (ALU_W+1)'(alu_cin);
   end

   always_comb begin
      diff_lo   = alu_sum[POS_W:0];
      diff_neg  = alu_sum[ALU_W-1];
      abs_diff  = diff_neg ? (~diff_lo + 1'b1) : diff_lo;
      big_jump  = abs_diff > HALF_TURN;
      width_pos = (alu_sum[ALU_W-1:0] == REV_X) ? REV_TOP : alu_sum[POS_W-1:0];
      rem_shift = {rem_ff, acc_ff[SUM_W-1]};
      if (abs_diff < DIR_LIM) begin
         new_dir = dir_ff;
      end else if ((!diff_neg && abs_diff != '0) != big_jump) begin
         new_dir = DIR_CW;
      end else begin
         new_dir = DIR_CCW;
      end
   end

   always_comb begin
      state_in       = state_ff;
      edge_time_in   = edge_time_ff;
      edge_level_in  = edge_level_ff;
      last_edge_in   = last_edge_ff;
      pulse_start_in = pulse_start_ff;
      last_pos_in    = last_pos_ff;
      turns_in       = turns_ff;
      dir_in         = dir_ff;
      status_in      = status_ff;
      cand_in        = cand_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      bit_cnt_in     = bit_cnt_ff;
      turn_up_in     = turn_up_ff;
      filt_en_in     = filt_en_ff;
      window_in      = window_ff;
      noise_in       = noise_ff;
      min_w_in       = min_w_ff;
      max_w_in       = max_w_ff;
      hist_cmd.clear = 1'b0;
      hist_cmd.push  = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_FILTER_EN: begin
               filt_en_in     = csr_wr_data[0];
               hist_cmd.clear = 1'b1;
            end
            CSR_WINDOW: begin
               window_in      = csr_wr_data[WIN_W-1:0];
               hist_cmd.clear = 1'b1;
            end
            CSR_NOISE: begin
               noise_in       = csr_wr_data;
               hist_cmd.clear = 1'b1;
            end
            CSR_MIN_WIDTH: min_w_in = csr_wr_data;
            CSR_MAX_WIDTH: max_w_in = csr_wr_data;
            default: begin
               filt_en_in = filt_en_ff;
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               edge_time_in  = req_if.edge_time;
               edge_level_in = req_if.edge_level;
               state_in      = S_GAP;
            end
         end
         S_GAP: begin
            if (alu_sum[ALU_W-1:0] < EDGE_GAP) begin
               status_in = ST_TIMING;
               state_in  = S_RESP;
            end else begin
               last_edge_in = edge_time_ff;
               if (edge_level_ff) begin
                  pulse_start_in = edge_time_ff;
                  status_in      = ST_START;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_WIDTH;
               end
            end
         end
         S_WIDTH: begin
            if (alu_sum[ALU_W-1:0] < ALU_W'(min_w_ff) ||
                alu_sum[ALU_W-1:0] > ALU_W'(max_w_ff)) begin
               status_in = ST_WIDTH;
               state_in  = S_RESP;
            end else if (width_pos == '0) begin
               status_in = ST_ZERO;
               state_in  = S_RESP;
            end else begin
               cand_in  = width_pos;
               state_in = S_NOISE;
            end
         end
         S_NOISE: begin
            if (filt_en_ff && noise_ff != '0 && abs_diff > (POS_W+1)'(noise_ff)) begin
               status_in = ST_NOISE;
               state_in  = S_RESP;
            end else if (filt_en_ff && window_ff != '0) begin
               hist_cmd.push = 1'b1;
               acc_in        = '0;
               state_in      = S_SUM;
            end else begin
               state_in = S_TRACK;
            end
         end
         S_SUM: begin
            if (hist_stat.rd_valid) begin
               acc_in = alu_sum[SUM_W-1:0];
               if (hist_stat.rd_last) begin
                  rem_in     = '0;
                  bit_cnt_in = DIV_STEPS;
                  state_in   = S_DIV;
               end
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit a cycle shifted into acc
            rem_in     = alu_sum[ALU_W] ? alu_sum[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            acc_in     = {acc_ff[SUM_W-2:0], alu_sum[ALU_W]};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BCNT_W'(1)) begin
               cand_in  = acc_in[POS_W-1:0];
               state_in = S_TRACK;
            end
         end
         S_TRACK: begin
            last_pos_in = cand_ff;
            if (abs_diff < STILL_LIM) begin
               status_in = ST_STILL;
               state_in  = S_RESP;
            end else begin
               dir_in    = new_dir;
               status_in = ST_MOVED;
               // wrap across zero moves the turn count
               if (new_dir == DIR_CW && diff_neg && big_jump) begin
                  turn_up_in = 1'b1;
                  state_in   = S_TURN;
               end else if (new_dir == DIR_CCW && !diff_neg && big_jump) begin
                  turn_up_in = 1'b0;
                  state_in   = S_TURN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_TURN: begin
            turns_in = alu_sum[ALU_W-1:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         last_edge_ff   <= '0;
         pulse_start_ff <= '0;
         last_pos_ff    <= '0;
         turns_ff       <= '0;
         dir_ff         <= DIR_UNKNOWN;
         status_ff      <= ST_MOVED;
         filt_en_ff     <= FILTER_EN_RST;
         window_ff      <= WINDOW_RST;
         noise_ff       <= NOISE_RST;
         min_w_ff       <= MIN_WIDTH_RST;
         max_w_ff       <= MAX_WIDTH_RST;
      end else begin
         state_ff       <= state_in;
         last_edge_ff   <= last_edge_in;
         pulse_start_ff <= pulse_start_in;
         last_pos_ff    <= last_pos_in;
         turns_ff       <= turns_in;
         dir_ff         <= dir_in;
         status_ff      <= status_in;
         filt_en_ff     <= filt_en_in;
         window_ff      <= window_in;
         noise_ff       <= noise_in;
         min_w_ff       <= min_w_in;
         max_w_ff       <= max_w_in;
      end
      edge_time_ff  <= edge_time_in;
      edge_level_ff <= edge_level_in;
      cand_ff       <= cand_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      turn_up_ff    <= turn_up_in;
   end

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = (state_ff == S_RESP);
   assign rsp_if.status    = status_ff;
   assign rsp_if.position  = last_pos_ff;
   assign rsp_if.turns     = signed'(turns_ff);
   assign rsp_if.direction = dir_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("taking an edge while a result beat is pending");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == S_GAP)
      else $error("accepted edge did not start the sequence");

   a_turn_moves: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TURN |=> turns_ff != $past(turns_ff))
      else $error("wrap detected but turn count unchanged");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the pwm absolute encoder tracker
// directed edge table, then random pulse trains
// depends on pwmaet_pkg, pwmaet_ifs and pwm_absolute_encoder_tracker
`default_nettype none

module tb_top;
   import pwmaet_pkg::*;

   localparam int PPR        = PULSES_PER_REV_DEF;
   localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
   localparam int STILL_LIM  = PPR / STILL_DIV;
   localparam int DIR_LIM    = PPR / DIR_DIV;
   localparam int HALF_TURN  = PPR / 2;

   // no register behind this index, writes must be dropped
   localparam csr_idx_type CSR_UNUSED = 3'd7;

   typedef struct packed {
      status_type               status;
      logic [POS_W-1:0]         position;
      logic signed [TURN_W-1:0] turns;
      dir_type                  direction;
   } trk_result_type;

   localparam trk_result_type NO_RES = '0;

   typedef struct {
      bit             reg_wr;
      csr_idx_type    idx;
      logic [31:0]    val;
      logic           lvl;
      bit             typed;
      trk_result_type res;
   } stim_row_type;

   typedef struct {
      logic [CSR_DATA_W-1:0] filt;
      logic [CSR_DATA_W-1:0] win;
      logic [CSR_DATA_W-1:0] noise;
      logic [CSR_DATA_W-1:0] min_w;
      logic [CSR_DATA_W-1:0] max_w;
   } csr_set_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   pwmaet_req_if req_bus ();
   pwmaet_rsp_if rsp_bus ();

   pwm_absolute_encoder_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   always #10 clock = ~clock;

   // register mirror
   logic             cfg_filter_en = FILTER_EN_RST;
   logic [WIN_W-1:0] cfg_window    = WINDOW_RST;
   logic [POS_W-1:0] cfg_noise     = NOISE_RST;
   logic [POS_W-1:0] cfg_min_w     = MIN_WIDTH_RST;
   logic [POS_W-1:0] cfg_max_w     = MAX_WIDTH_RST;

   // tracker state mirror
   logic [31:0]              pr_last_edge   = '0;
   logic [31:0]              pr_pulse_start = '0;
   logic [POS_W-1:0]         pr_hist [HIST_DEPTH] = '{default: '0};
   int                       pr_hist_idx    = 0;
   int                       pr_hist_cnt    = 0;
   logic [POS_W-1:0]         pr_last_pos    = '0;
   logic signed [TURN_W-1:0] pr_turns       = '0;
   dir_type                  pr_dir         = DIR_UNKNOWN;

   trk_result_type expected_q [$];
   int          fault_count = 0;
   int          beat_count  = 0;
   int          send_quiet  = 0;
   int          recv_quiet  = 0;
   int          recv_hold   = 0;
   logic [31:0] last_t      = '0;
   logic [31:0] last_rise   = '0;
   int          shaft       = 0;

   stim_row_type directed_rows [29] = '{
      '{1'b0, CSR_FILTER_EN, 32'd1,     1'b1, 1'b1, '{ST_TIMING, 13'd0, 32'sd0, DIR_UNKNOWN}},
      '{1'b0, CSR_FILTER_EN, 32'd0,     1'b0, 1'b1, '{ST_TIMING, 13'd0, 32'sd0, DIR_UNKNOWN}},
      '{1'b0, CSR_FILTER_EN, 32'd100,   1'b1, 1'b1, '{ST_START, 13'd0, 32'sd0, DIR_UNKNOWN}},
      '{1'b0, CSR_FILTER_EN, 32'd101,   1'b0, 1'b1, '{ST_TIMING, 13'd0, 32'sd0, DIR_UNKNOWN}},
      '{1'b0, CSR_FILTER_EN, 32'd102,   1'b0, 1'b1, '{ST_STILL, 13'd1, 32'sd0, DIR_UNKNOWN}},
      '{1'b0, CSR_FILTER_EN, 32'd1000,  1'b0, 1'b0, NO_RES},
      // zero high time wraps to a huge width
      '{1'b0, CSR_FILTER_EN, 32'd100,   1'b0, 1'b1, '{ST_WIDTH, 13'd450, 32'sd0, DIR_CW}},
      '{1'b0, CSR_FILTER_EN, 32'd2000,  1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd6098,  1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd7000,  1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd11099, 1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd12000, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd16097, 1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'hFFFF_FF00, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'h0000_0010, 1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'h0000_0011, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'h0000_0012, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'h0000_0014, 1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
      '{1'b1, CSR_MIN_WIDTH, 32'd0,     1'b0, 1'b0, NO_RES},
      '{1'b1, CSR_MAX_WIDTH, 32'd8191,  1'b0, 1'b0, NO_RES},
      '{1'b1, CSR_NOISE,     32'd100,   1'b0, 1'b0, NO_RES},
      '{1'b1, CSR_UNUSED,    32'h1FFF,  1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd20000, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd20500, 1'b0, 1'b0, NO_RES},
      // time steps back to one past the pulse start: zero position
      '{1'b0, CSR_FILTER_EN, 32'd20001, 1'b0, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd40000, 1'b1, 1'b0, NO_RES},
      '{1'b0, CSR_FILTER_EN, 32'd48001, 1'b0, 1'b0, NO_RES}
   };

   csr_set_type fixed_sets [9] = '{
      '{13'd1,      13'd16,     13'd0,    13'd1,    13'd4097},
      '{13'd0,      13'd16,     13'd0,    13'd1,    13'd4097},
      '{13'd1,      13'd0,      13'd0,    13'd1,    13'd4097},
      '{13'd1,      13'd1,      13'd200,  13'd1,    13'd4097},
      '{13'h1FFF,   13'd4,      13'd8191, 13'd0,    13'd8191},
      '{13'd1,      13'd16,     13'd1,    13'd0,    13'd8191},
      '{13'h1FFE,   13'h1FF0,   13'd0,    13'd8191, 13'd0},
      '{13'd1,      13'd31,     13'd50,   13'd100,  13'd4000},
      '{13'd0,      13'd0,      13'd8191, 13'd0,    13'd4096}
   };

   function automatic int idle_cycles(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) quiet = $urandom_range(8, 40);
      return $urandom_range(0, 12);
   endfunction

   // advances the mirrored state by one edge and returns the beat it should produce
   function automatic trk_result_type track_edge(input logic [31:0] t, input logic lvl);
      logic [31:0]      gap_us;
      logic [31:0]      x;
      logic [POS_W-1:0] pos;
      int               diff;
      int               ad;
      int               n;
      int               first;
      int               sum;
      int               i;
      dir_type          nd;
      status_type       st;
      trk_result_type   r;
      gap_us = t - pr_last_edge;
      if (gap_us < 32'(MIN_EDGE_GAP)) begin
         st = ST_TIMING;
      end else begin
         pr_last_edge = t;
         if (lvl) begin
            pr_pulse_start = t;
            st = ST_START;
         end else begin
            x = t - pr_pulse_start - 32'd1;
            if (x < cfg_min_w || x > cfg_max_w) begin
               st = ST_WIDTH;
            end else begin
               pos = (x == PPR) ? POS_W'(PPR - 1) : x[POS_W-1:0];
               diff = int'(pos) - int'(pr_last_pos);
               ad = (diff < 0) ? -diff : diff;
               if (pos == '0) begin
                  st = ST_ZERO;
               end else if (cfg_filter_en && cfg_noise != '0 && ad > cfg_noise) begin
                  st = ST_NOISE;
               end else begin
                  if (cfg_filter_en && cfg_window != '0) begin
                     pr_hist[pr_hist_idx] = pos;
                     pr_hist_idx = (pr_hist_idx + 1) % HIST_DEPTH;
                     if (pr_hist_cnt < HIST_DEPTH) pr_hist_cnt++;
                     n = (pr_hist_cnt < cfg_window) ? pr_hist_cnt : int'(cfg_window);
                     first = (pr_hist_idx + HIST_DEPTH - n) % HIST_DEPTH;
                     sum = 0;
                     for (i = 0; i < n; i++) sum += pr_hist[(first + i) % HIST_DEPTH];
                     pos = POS_W'(sum / n);
                  end
                  diff = int'(pos) - int'(pr_last_pos);
                  ad = (diff < 0) ? -diff : diff;
                  if (ad < STILL_LIM) begin
                     pr_last_pos = pos;
                     st = ST_STILL;
                  end else begin
                     if (ad < DIR_LIM) nd = pr_dir;
                     else nd = ((diff > 0) != (ad > HALF_TURN)) ? DIR_CW : DIR_CCW;
                     // a jump over half a turn against the direction means a wrap
                     if (nd == DIR_CW && pr_last_pos > pos && ad > HALF_TURN)
                        pr_turns = pr_turns + 32'sd1;
                     else if (nd == DIR_CCW && pr_last_pos < pos && ad > HALF_TURN)
                        pr_turns = pr_turns - 32'sd1;
                     pr_dir = nd;
                     pr_last_pos = pos;
                     st = ST_MOVED;
                  end
               end
            end
         end
      end
      r.status    = st;
      r.position  = pr_last_pos;
      r.turns     = pr_turns;
      r.direction = pr_dir;
      return r;
   endfunction

   // all driving tasks start and end on a falling edge
   task automatic send_edge(input logic [31:0] t, input logic lvl, input bit typed,
                            input trk_result_type typed_res);
      int             gap;
      trk_result_type r;
      gap = idle_cycles(send_quiet);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.edge_time  = t;
      req_bus.edge_level = lvl;
      do @(posedge clock); while (!req_bus.ready);
      r = track_edge(t, lvl);
      expected_q.push_back(typed ? typed_res : r);
      last_t = t;
      if (lvl) last_rise = t;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      case (idx)
         CSR_FILTER_EN: cfg_filter_en = data[0];
         CSR_WINDOW:    cfg_window    = data[WIN_W-1:0];
         CSR_NOISE:     cfg_noise     = data[POS_W-1:0];
         CSR_MIN_WIDTH: cfg_min_w     = data[POS_W-1:0];
         CSR_MAX_WIDTH: cfg_max_w     = data[POS_W-1:0];
         default: ;
      endcase
      // filter settings restart the averaging window
      if (idx == CSR_FILTER_EN || idx == CSR_WINDOW || idx == CSR_NOISE) begin
         pr_hist     = '{default: '0};
         pr_hist_idx = 0;
         pr_hist_cnt = 0;
      end
   endtask

   task automatic random_edges(input int n_items);
      int          sent;
      int          pick;
      int          step;
      int          mag;
      logic [31:0] t_rise;
      logic [31:0] width;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 199) == 0) drain_results();
         if (pick < 78) begin
            // well-formed pulse whose width follows a moving shaft
            step = $urandom_range(0, 99);
            if (step < 30) mag = $urandom_range(0, STILL_LIM - 1);
            else if (step < 60) mag = $urandom_range(STILL_LIM, 200);
            else if (step < 75) mag = $urandom_range(HALF_TURN + 1, PPR - 1);
            else mag = $urandom_range(0, PPR - 1);
            if ($urandom_range(0, 1)) mag = -mag;
            shaft = ((shaft + mag) % PPR + PPR) % PPR;
            width = 32'(shaft);
            if (step >= 88) begin
               case ($urandom_range(0, 7))
                  0: width = PPR;
                  1: width = PPR - 1;
                  2: width = {19'd0, cfg_min_w};
                  3: width = {19'd0, cfg_max_w};
                  4: width = {19'd0, cfg_min_w} - 32'd1;
                  5: width = {19'd0, cfg_max_w} + 32'd1;
                  6: width = $urandom_range(PPR, 8191);
                  default: width = 32'd1;
               endcase
            end
            case ($urandom_range(0, 19))
               0: t_rise = last_t + $urandom;
               1: t_rise = last_t + $urandom_range(3001, 32'hF000_0000);
               default: t_rise = last_t + $urandom_range(2, 3000);
            endcase
            send_edge(t_rise, 1'b1, 1'b0, NO_RES);
            send_edge(t_rise + width + 32'd1, 1'b0, 1'b0, NO_RES);
            sent += 2;
         end else begin
            if (pick < 86)
               send_edge(last_t + $urandom_range(0, 1), 1'($urandom), 1'b0, NO_RES);
            else if (pick < 92)
               send_edge(last_t + $urandom_range(2, 9000), 1'($urandom), 1'b0, NO_RES);
            else if (pick < 96)
               send_edge(last_rise + $urandom_range(0, 1), 1'b0, 1'b0, NO_RES);
            else
               send_edge($urandom, 1'($urandom), 1'b0, NO_RES);
            sent++;
         end
      end
   endtask

   task automatic run_phase(input csr_set_type s, input int n_items);
      drain_results();
      write_reg(CSR_FILTER_EN, s.filt);
      write_reg(CSR_WINDOW,    s.win);
      write_reg(CSR_NOISE,     s.noise);
      write_reg(CSR_MIN_WIDTH, s.min_w);
      write_reg(CSR_MAX_WIDTH, s.max_w);
      if ($urandom_range(0, 2) == 0)
         write_reg(csr_idx_type'($urandom_range(5, 7)), CSR_DATA_W'($urandom));
      last_t = $urandom;
      random_edges(n_items);
   endtask

   // result side: random back-pressure and in-order compare
   initial begin
      trk_result_type got;
      trk_result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status    = rsp_bus.status;
            got.position  = rsp_bus.position;
            got.turns     = rsp_bus.turns;
            got.direction = rsp_bus.direction;
            if (expected_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("beat %0d arrived with nothing expected: status %0d pos %0d",
                           beat_count, got.status, got.position);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"beat %0d: exp st %0d pos %0d turns %0d dir %0d,",
                               " got st %0d pos %0d turns %0d dir %0d"},
                              beat_count, want.status, want.position, want.turns,
                              want.direction, got.status, got.position, got.turns,
                              got.direction);
               end
            end
            beat_count++;
            recv_hold = idle_cycles(recv_quiet);
         end
         @(negedge clock);
         if (recv_hold > 0) begin
            rsp_bus.ready = 1'b0;
            recv_hold--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   initial begin
      int          k;
      csr_set_type rs;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_FILTER_EN;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.edge_time  = '0;
      req_bus.edge_level = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < 29; k++) begin
         if (directed_rows[k].reg_wr) begin
            drain_results();
            write_reg(directed_rows[k].idx, directed_rows[k].val[CSR_DATA_W-1:0]);
         end else begin
            send_edge(directed_rows[k].val, directed_rows[k].lvl, directed_rows[k].typed,
                      directed_rows[k].res);
         end
      end

      for (k = 0; k < 9; k++) run_phase(fixed_sets[k], 110);

      for (k = 0; k < 8; k++) begin
         rs.filt  = CSR_DATA_W'($urandom);
         rs.win   = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom)
                                                : CSR_DATA_W'($urandom_range(0, 16));
         case ($urandom_range(0, 3))
            0: rs.noise = '0;
            1: rs.noise = CSR_DATA_W'($urandom);
            default: rs.noise = CSR_DATA_W'($urandom_range(1, 300));
         endcase
         rs.min_w = $urandom_range(0, 1) ? CSR_DATA_W'($urandom_range(0, 50))
                                         : CSR_DATA_W'($urandom);
         rs.max_w = $urandom_range(0, 1) ? CSR_DATA_W'($urandom_range(4000, 8191))
                                         : CSR_DATA_W'($urandom);
         run_phase(rs, 110);
      end

      drain_results();
      repeat (60) @(posedge clock);
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #16_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
sv/pwmaet_pkg.sv
sv/pwmaet_ifs.sv
sv/pwmaet_hist.sv
sv/pwm_absolute_encoder_tracker.sv
bench/tb_top.sv
